// ===== design/vss_pkg.sv =====
// Shared types, constants and helpers for the VAD speech segmenter.
// No dependencies; imported by the csr, tracker, pad/clamp and top-level modules.
`timescale 1ns / 1ps

package vss_pkg;

   // Position counters and segment bounds
   localparam int POS_W  = 32;
   // Signed compare width: holds any position or 32-bit register, plus sign
   localparam int CMP_W  = ((POS_W > 32) ? POS_W : 32) + 2;
   localparam int OUT_W  = 32;
   localparam int WS_W   = 13;
   localparam int IDX_W  = 3;
   localparam int DATA_W = 32;

   typedef logic [POS_W-1:0]        pos_type;
   typedef logic [POS_W:0]          ext_type;
   typedef logic signed [CMP_W-1:0] cmp_type;

   typedef enum logic [1:0] {
      ACT_START  = 2'd0,
      ACT_WINDOW = 2'd1,
      ACT_END    = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      KIND_SPLIT   = 2'd0,
      KIND_SILENCE = 2'd1,
      KIND_FLUSH   = 2'd2
   } kind_type;

   // Register indexes
   localparam logic [IDX_W-1:0] CSR_THRESHOLD   = 3'd0;
   localparam logic [IDX_W-1:0] CSR_WIN_STEP    = 3'd1;
   localparam logic [IDX_W-1:0] CSR_MIN_SILENCE = 3'd2;
   localparam logic [IDX_W-1:0] CSR_MIN_SPEECH  = 3'd3;
   localparam logic [IDX_W-1:0] CSR_MAX_SPEECH  = 3'd4;
   localparam logic [IDX_W-1:0] CSR_PAD         = 3'd5;

   typedef struct packed {
      logic [15:0]     threshold;
      logic [WS_W-1:0] win_step;
      logic [23:0]     min_silence;
      logic [23:0]     min_speech;
      logic [31:0]     max_speech;
      logic [23:0]     pad;
   } cfg_type;

   // Unpadded segment handed from the tracker to the pad/clamp stage
   typedef struct packed {
      pos_type  seg_s;
      ext_type  seg_e;
      pos_type  total;
      kind_type kind;
   } cand_type;

   function automatic cmp_type to_cmp(input pos_type v);
      return cmp_type'(v);
   endfunction

   // Saturating position advance
   function automatic pos_type sat_add(input pos_type a, input logic [WS_W-1:0] b);
      logic [POS_W:0] s;
      s = {1'b0, a} + (POS_W+1)'(b);
      return s[POS_W] ? {POS_W{1'b1}} : s[POS_W-1:0];
   endfunction

endpackage

// ===== design/vss_csr.sv =====
// Configuration register file of the VAD speech segmenter.
// Depends on vss_pkg.
`timescale 1ns / 1ps

module vss_csr (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_write_en,
   input  logic [vss_pkg::IDX_W-1:0]  csr_index,
   input  logic [vss_pkg::DATA_W-1:0] csr_wdata,
   output vss_pkg::cfg_type         cfg
);
   import vss_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_THRESHOLD:   cfg_in.threshold   = csr_wdata[15:0];
            CSR_WIN_STEP:    cfg_in.win_step    = csr_wdata[WS_W-1:0];
            CSR_MIN_SILENCE: cfg_in.min_silence = csr_wdata[23:0];
            CSR_MIN_SPEECH:  cfg_in.min_speech  = csr_wdata[23:0];
            CSR_MAX_SPEECH:  cfg_in.max_speech  = csr_wdata[31:0];
            CSR_PAD:         cfg_in.pad         = csr_wdata[23:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.threshold   <= 16'd32768;
         cfg_ff.win_step    <= 13'd512;
         cfg_ff.min_silence <= 24'd1600;
         cfg_ff.min_speech  <= 24'd4000;
         cfg_ff.max_speech  <= 32'd480000;
         cfg_ff.pad         <= 24'd480;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== design/vss_tracker.sv =====
// Segment tracker: run state update per input beat, unpadded segment register.
// Depends on vss_pkg.
`timescale 1ns / 1ps

module vss_tracker (
   input  logic                 clock,
   input  logic                 reset,
   input  vss_pkg::cfg_type     cfg,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [1:0]           req_action,
   input  logic [15:0]          req_prob_level,
   input  logic [31:0]          req_audio_length,
   output logic                 cand_valid,
   output vss_pkg::cand_type    cand,
   input  logic                 down_ready
);
   import vss_pkg::*;

   logic     open_ff, open_in;
   pos_type  begin_ff, begin_in;
   pos_type  silence_ff, silence_in;
   pos_type  position_ff, position_in;
   pos_type  total_ff, total_in;
   logic     cand_valid_ff, cand_valid_in;
   cand_type cand_ff, cand_in;
   logic     accept;
   logic     emit;

   assign req_ready = !cand_valid_ff || down_ready;
   assign accept    = req_valid && req_ready;

   always_comb begin
      pos_type p;
      pos_type b;
      pos_type sr;
      cmp_type e;
      cmp_type len;

      p           = position_ff;
      b           = begin_ff;
      sr          = silence_ff;
      e           = '0;
      len         = '0;
      open_in     = open_ff;
      begin_in    = begin_ff;
      silence_in  = silence_ff;
      position_in = position_ff;
      total_in    = total_ff;
      emit        = 1'b0;
      cand_in.seg_s = begin_ff;
      cand_in.seg_e = ext_type'(position_ff);
      cand_in.total = total_ff;
      cand_in.kind  = KIND_SPLIT;

      if (accept) begin
         case (req_action)
            ACT_START: begin
               open_in     = 1'b0;
               begin_in    = '0;
               silence_in  = '0;
               position_in = '0;
               total_in    = pos_type'(req_audio_length);
            end
            ACT_WINDOW: begin
               if (req_prob_level >= cfg.threshold) begin
                  b          = open_ff ? begin_ff : p;
                  open_in    = 1'b1;
                  begin_in   = b;
                  silence_in = '0;
                  if (p >= b && to_cmp(p - b) > cmp_type'(cfg.max_speech)) begin
                     emit          = 1'b1;
                     cand_in.seg_s = b;
                     cand_in.seg_e = ext_type'(p);
                     cand_in.kind  = KIND_SPLIT;
                     begin_in      = p;
                  end
               end else if (open_ff) begin
                  sr = sat_add(silence_ff, cfg.win_step);
                  silence_in = sr;
                  if (to_cmp(sr) >= cmp_type'(cfg.min_silence)) begin
                     // segment end = first silent sample of the run
                     e = to_cmp(p) + cmp_type'(cfg.win_step) - to_cmp(sr);
                     if (e < 0) begin
                        e = '0;
                     end
                     len = e - to_cmp(begin_ff);
                     if (len >= cmp_type'(cfg.min_speech)) begin
                        emit          = 1'b1;
                        cand_in.seg_s = begin_ff;
                        cand_in.seg_e = ext_type'(e);
                        cand_in.kind  = KIND_SILENCE;
                     end
                     open_in    = 1'b0;
                     silence_in = '0;
                  end
               end
               position_in = sat_add(position_ff, cfg.win_step);
            end
            ACT_END: begin
               if (open_ff) begin
                  len = to_cmp(total_ff) - to_cmp(begin_ff);
                  if (len >= cmp_type'(cfg.min_speech)) begin
                     emit          = 1'b1;
                     cand_in.seg_s = begin_ff;
                     cand_in.seg_e = ext_type'(total_ff);
                     cand_in.kind  = KIND_FLUSH;
                  end
                  open_in    = 1'b0;
                  silence_in = '0;
               end
            end
            default: begin
               open_in = open_ff;
            end
         endcase
      end

      if (accept) begin
         cand_valid_in = emit;
      end else if (down_ready) begin
         cand_valid_in = 1'b0;
      end else begin
         cand_valid_in = cand_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff       <= 1'b0;
         begin_ff      <= '0;
         silence_ff    <= '0;
         position_ff   <= '0;
         total_ff      <= '0;
         cand_valid_ff <= 1'b0;
      end else begin
         open_ff       <= open_in;
         begin_ff      <= begin_in;
         silence_ff    <= silence_in;
         position_ff   <= position_in;
         total_ff      <= total_in;
         cand_valid_ff <= cand_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && emit) begin
         cand_ff <= cand_in;
      end
   end

   assign cand_valid = cand_valid_ff;
   assign cand       = cand_ff;

endmodule

// ===== design/vss_pad_clamp.sv =====
// Output stage: pads a segment, clamps it to [0, audio length], holds the beat.
// Depends on vss_pkg.
`timescale 1ns / 1ps

module vss_pad_clamp (
   input  logic              clock,
   input  logic              reset,
   input  logic [23:0]       pad,
   input  logic              cand_valid,
   input  vss_pkg::cand_type cand,
   output logic              down_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [31:0]       rsp_seg_start,
   output logic [31:0]       rsp_seg_end,
   output logic [1:0]        rsp_seg_kind
);
   import vss_pkg::*;

   logic                  valid_ff, valid_in;
   logic [OUT_W-1:0]      start_ff, start_in;
   logic [OUT_W-1:0]      end_ff, end_in;
   kind_type              kind_ff;
   logic                  load;
   pos_type               ps;
   logic [POS_W+1:0]      pe;

   assign down_ready = !valid_ff || rsp_ready;
   assign load       = cand_valid && down_ready;

   always_comb begin
      if (to_cmp(cand.seg_s) < cmp_type'(pad)) begin
         ps = '0;
      end else begin
         ps = cand.seg_s - pos_type'(pad);
      end
      pe = (POS_W+2)'(cand.seg_e) + (POS_W+2)'(pad);
      if (pe > (POS_W+2)'(cand.total)) begin
         pe = (POS_W+2)'(cand.total);
      end
      start_in = OUT_W'(ps);
      end_in   = OUT_W'(pe);
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         start_ff <= start_in;
         end_ff   <= end_in;
         kind_ff  <= cand.kind;
      end
   end

   assign rsp_valid     = valid_ff;
   assign rsp_seg_start = start_ff;
   assign rsp_seg_end   = end_ff;
   assign rsp_seg_kind  = kind_ff;

endmodule

// ===== design/vad_speech_segmenter.sv =====
// Top level of the VAD speech segmenter: register file, tracker, pad/clamp stage.
// Depends on vss_pkg, vss_csr, vss_tracker, vss_pad_clamp.
`timescale 1ns / 1ps
//
// Usage
//  - req channel (valid/ready): one beat per audio window (action WINDOW with
//    prob_level), plus START beats (latch audio_length, clear the run) and END
//    beats (flush an open segment at the audio length). Action code 3 is a no-op.
//  - rsp channel (valid/ready): zero or one beat per request: padded, clamped
//    segment start/end in samples and the reason it closed (split/silence/flush).
//  - csr port: one-cycle writes, index per register list; only while idle.
//  - Throughput: one request beat per cycle while not stalled (see Stall).
//    Tracker state updates at the accepting edge; the next beat can follow in
//    the next cycle. A segment reaches rsp through the tracker segment register,
//    then the pad/clamp output register.
//  - Stall: with rsp held, one more segment waits in the tracker register;
//    requests that make no segment keep flowing until that slot is needed.
//  - Reset (synchronous): run state clears, registers take default values,
//    both channels empty.
//
module vad_speech_segmenter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_action,
   input  logic [15:0] req_prob_level,
   input  logic [31:0] req_audio_length,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_seg_start,
   output logic [31:0] rsp_seg_end,
   output logic [1:0]  rsp_seg_kind,
   input  logic        csr_write_en,
   input  logic [vss_pkg::IDX_W-1:0]  csr_index,
   input  logic [vss_pkg::DATA_W-1:0] csr_wdata
);
   import vss_pkg::*;

   cfg_type  cfg;
   cand_type cand;
   logic     cand_valid;
   logic     down_ready;

   vss_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cfg          (cfg)
   );

   // Decision logic: open/extend/split/close per window
   vss_tracker u_tracker (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_action       (req_action),
      .req_prob_level   (req_prob_level),
      .req_audio_length (req_audio_length),
      .cand_valid       (cand_valid),
      .cand             (cand),
      .down_ready       (down_ready)
   );

   // Padding, clamping and the output register
   vss_pad_clamp u_pad_clamp (
      .clock         (clock),
      .reset         (reset),
      .pad           (cfg.pad),
      .cand_valid    (cand_valid),
      .cand          (cand),
      .down_ready    (down_ready),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_seg_start (rsp_seg_start),
      .rsp_seg_end   (rsp_seg_end),
      .rsp_seg_kind  (rsp_seg_kind)
   );

endmodule

// ===== design/vss_checker.sv =====
// Port-level checks for the VAD speech segmenter, bound to the top level.
// Depends on vad_speech_segmenter.
`timescale 1ns / 1ps

module vss_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_seg_start,
   input logic [31:0] rsp_seg_end,
   input logic [1:0]  rsp_seg_kind
);

   // Stalled beat holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_seg_start)
         && $stable(rsp_seg_end) && $stable(rsp_seg_kind))
      else $error("rsp beat changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   // A fresh result traces back to an accepted request beat
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("rsp beat without a request beat");

   // With an empty output, the input side never blocks
   a_no_bubble: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("req not ready while output empty");

endmodule

bind vad_speech_segmenter vss_checker u_vss_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_seg_start (rsp_seg_start),
   .rsp_seg_end   (rsp_seg_end),
   .rsp_seg_kind  (rsp_seg_kind)
);
